/* sv/sdps_pkg.sv */
package sdps_pkg;

   // defaults for the top level parameters
   localparam int PAGES_DEF    = 8;
   localparam int DIGITS_DEF   = 8;
   localparam int TEXT_LEN_DEF = 32;

   // at most this many digits are emitted per draw
   localparam int MAX_EMIT = 8;

   // character codes
   localparam logic [7:0] DOT_CHAR   = 8'h2E;
   localparam logic [7:0] POINT_BIT  = 8'h80;
   localparam logic [7:0] BLANK_CHAR = 8'h20;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_ON     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_ENABLE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_PERIOD  = 3'd5;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_PUT   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    command;
      logic [2:0] page;
      logic [7:0] char_in;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0] digit_index;
      logic [7:0] segment_char;
      logic       last_digit;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE       = 3'd0,
      ST_TICK       = 3'd1,
      ST_CLEAR      = 3'd2,
      ST_PUT        = 3'd3,
      ST_MERGE      = 3'd4,
      ST_DRAW_SETUP = 3'd5,
      ST_DRAW       = 3'd6
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic tick;
      logic clear;
      logic put_direct;
      logic merge_rd;
      logic merge_fin;
      logic draw_setup;
      logic draw_step;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic merge_needed;
      logic draw_last;
   } sts_type;

endpackage

/* sv/sdps_ctrl.sv */
module sdps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sdps_pkg::cmd_type command,
   input  sdps_pkg::sts_type sts,
   output sdps_pkg::ctl_type ctl,
   output logic              busy
);

   sdps_pkg::state_type state_ff;
   sdps_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = reset || (state_ff != sdps_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         sdps_pkg::ST_IDLE: begin
            if (start && !reset) begin
               ctl.capture = 1'b1;
               unique case (command)
                  sdps_pkg::CMD_TICK:  state_in = sdps_pkg::ST_TICK;
                  sdps_pkg::CMD_DRAW:  state_in = sdps_pkg::ST_DRAW_SETUP;
                  sdps_pkg::CMD_PUT:   state_in = sdps_pkg::ST_PUT;
                  sdps_pkg::CMD_CLEAR: state_in = sdps_pkg::ST_CLEAR;
               endcase
            end
         end
         sdps_pkg::ST_TICK: begin
            ctl.tick = 1'b1;
            state_in = sdps_pkg::ST_IDLE;
         end
         sdps_pkg::ST_CLEAR: begin
            ctl.clear = 1'b1;
            state_in  = sdps_pkg::ST_IDLE;
         end
         sdps_pkg::ST_PUT: begin
            if (sts.merge_needed) begin
               ctl.merge_rd = 1'b1;
               state_in     = sdps_pkg::ST_MERGE;
            end else begin
               ctl.put_direct = 1'b1;
               state_in       = sdps_pkg::ST_IDLE;
            end
         end
         sdps_pkg::ST_MERGE: begin
            ctl.merge_fin = 1'b1;
            state_in      = sdps_pkg::ST_IDLE;
         end
         sdps_pkg::ST_DRAW_SETUP: begin
            ctl.draw_setup = 1'b1;
            state_in       = sdps_pkg::ST_DRAW;
         end
         sdps_pkg::ST_DRAW: begin
            ctl.draw_step = 1'b1;
            if (sts.draw_last) begin
               state_in = sdps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/sdps_datapath.sv */
module sdps_datapath #(
   parameter int PAGES    = sdps_pkg::PAGES_DEF,
   parameter int DIGITS   = sdps_pkg::DIGITS_DEF,
   parameter int TEXT_LEN = sdps_pkg::TEXT_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sdps_pkg::ctl_type                 ctl,
   output sdps_pkg::sts_type                 sts,
   input  sdps_pkg::req_type                 req_item,
   input  logic                              csr_we,
   input  logic [sdps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sdps_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                              rsp_valid,
   output sdps_pkg::rsp_type                 rsp_item
);

   localparam int MEM_DEPTH = PAGES * TEXT_LEN;
   localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int WI_W      = $clog2(TEXT_LEN + 1);
   localparam int LEN_W     = $clog2(TEXT_LEN);
   localparam int NPG       = (PAGES < 8) ? PAGES : 8;
   localparam int LIW       = (NPG > 1) ? $clog2(NPG) : 1;
   localparam int NUM_EMIT  = (DIGITS < sdps_pkg::MAX_EMIT) ? DIGITS : sdps_pkg::MAX_EMIT;
   localparam int CNT_W     = (NUM_EMIT > 1) ? $clog2(NUM_EMIT) : 1;
   localparam int POS_W     = $clog2(DIGITS + TEXT_LEN + 256) + 1;
   localparam logic signed [POS_W-1:0] POS_BASE   = POS_W'(1 - DIGITS);
   localparam logic signed [POS_W-1:0] POS_DIGITS = POS_W'(DIGITS);

   // configuration
   logic [3:0] page_count_ff;
   logic [6:0] rotate_period_ff;
   logic       scroll_on_ff;
   logic [6:0] scroll_period_ff;
   logic       blink_en_ff;
   logic [6:0] blink_period_ff;

   // timers and page rotation
   logic [2:0]        cur_page_ff;
   logic signed [7:0] scroll_offset_ff;
   logic [6:0]        scroll_count_ff;
   logic [6:0]        rotate_count_ff;
   logic [6:0]        blink_count_ff;
   logic              blink_phase_ff;

   // put stream
   sdps_pkg::req_type item_ff;
   logic [WI_W-1:0]   wi_ff;
   logic              prev_dot_ff;
   logic              at_start_ff;
   logic [LEN_W-1:0]  len_ff [NPG];

   // text store
   logic [7:0] mem [MEM_DEPTH];
   logic [7:0] rd_data_ff;

   // draw
   logic signed [POS_W-1:0] pos_ff;
   logic [LEN_W-1:0]        slen_ff;
   logic                    draw_blank_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    rsp_valid_ff;
   logic [2:0]              rsp_digit_ff;
   logic                    rsp_last_ff;
   logic                    rsp_blank_ff;

   // put stream logic
   logic             put_pg_ok;
   logic             is_dot;
   logic             merge_needed;
   logic [WI_W-1:0]  cell_idx;
   logic             cell_ok;
   logic [AW-1:0]    cell_addr;
   logic [WI_W-1:0]  wi_in;
   logic [LEN_W-1:0] commit_len;
   logic [7:0]       wr_data;
   logic             mem_we;
   logic [LIW-1:0]   put_len_idx;

   // page change on this tick
   logic             rotate_now;

   assign put_pg_ok    = int'(item_ff.page) < PAGES;
   assign is_dot       = item_ff.char_in == sdps_pkg::DOT_CHAR;
   assign merge_needed = is_dot && !at_start_ff && !prev_dot_ff && (wi_ff != '0);
   assign cell_idx     = merge_needed ? wi_ff - 1'b1 : wi_ff;
   assign cell_ok      = put_pg_ok && (int'(cell_idx) < TEXT_LEN - 1);
   assign cell_addr    = AW'(item_ff.page) * AW'(TEXT_LEN) + AW'(cell_idx);
   assign put_len_idx  = item_ff.page[LIW-1:0];
   assign rotate_now   = (page_count_ff > 4'd1) && (rotate_count_ff >= rotate_period_ff);

   always_comb begin
      if (merge_needed || int'(wi_ff) >= TEXT_LEN) begin
         wi_in = wi_ff;
      end else begin
         wi_in = wi_ff + 1'b1;
      end
      if (int'(wi_in) > TEXT_LEN - 1) begin
         commit_len = LEN_W'(TEXT_LEN - 1);
      end else begin
         commit_len = LEN_W'(wi_in);
      end
      priority if (ctl.merge_fin) begin
         wr_data = rd_data_ff | sdps_pkg::POINT_BIT;
      end else if (is_dot) begin
         wr_data = sdps_pkg::BLANK_CHAR | sdps_pkg::POINT_BIT;
      end else begin
         wr_data = item_ff.char_in;
      end
   end

   assign mem_we = (ctl.put_direct || ctl.merge_fin) && cell_ok;

   // draw logic
   logic                    cur_ok;
   logic [LIW-1:0]          cur_len_idx;
   logic [LEN_W-1:0]        slen_cur;
   logic signed [POS_W-1:0] slen_s;
   logic                    blank_now;
   logic signed [POS_W-1:0] pos_in;
   logic                    scroll_reset;
   logic signed [POS_W-1:0] j_pos;
   logic                    j_ok;
   logic [AW-1:0]           draw_addr;
   logic                    draw_last;

   assign cur_ok      = int'(cur_page_ff) < PAGES;
   assign cur_len_idx = cur_page_ff[LIW-1:0];
   assign slen_cur    = cur_ok ? len_ff[cur_len_idx] : '0;
   assign slen_s      = signed'(POS_W'(slen_cur));
   assign blank_now   = blink_en_ff && !blink_phase_ff;

   always_comb begin
      scroll_reset = 1'b0;
      if (scroll_on_ff) begin
         pos_in = POS_BASE + POS_W'(scroll_offset_ff);
         if (!blank_now && (slen_s < pos_in)) begin
            pos_in       = POS_BASE;
            scroll_reset = 1'b1;
         end
      end else if (slen_s > POS_DIGITS) begin
         pos_in = '0;
      end else begin
         pos_in = slen_s - POS_DIGITS;
      end
   end

   // one digit per cycle from the single read port of the text store
   assign j_pos     = pos_ff + signed'(POS_W'(cnt_ff));
   assign j_ok      = !draw_blank_ff && !j_pos[POS_W-1]
                      && (j_pos < signed'(POS_W'(slen_ff)));
   assign draw_addr = AW'(cur_page_ff) * AW'(TEXT_LEN) + AW'(unsigned'(j_pos));
   assign draw_last = cnt_ff == CNT_W'(NUM_EMIT - 1);

   assign sts.merge_needed = merge_needed;
   assign sts.draw_last    = draw_last;

   // text store, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cell_addr] <= wr_data;
      end
      if (ctl.merge_rd) begin
         rd_data_ff <= mem[cell_addr];
      end else if (ctl.draw_step) begin
         rd_data_ff <= mem[draw_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         item_ff <= req_item;
      end
      if (ctl.draw_setup) begin
         pos_ff        <= pos_in;
         slen_ff       <= slen_cur;
         draw_blank_ff <= blank_now;
      end
      if (ctl.draw_step) begin
         rsp_digit_ff <= 3'(cnt_ff);
         rsp_blank_ff <= !j_ok;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff    <= '0;
         rotate_period_ff <= '0;
         scroll_on_ff     <= 1'b0;
         scroll_period_ff <= '0;
         blink_en_ff      <= 1'b0;
         blink_period_ff  <= '0;
         cur_page_ff      <= '0;
         scroll_offset_ff <= '0;
         scroll_count_ff  <= '0;
         rotate_count_ff  <= '0;
         blink_count_ff   <= '0;
         blink_phase_ff   <= 1'b0;
         wi_ff            <= '0;
         prev_dot_ff      <= 1'b0;
         at_start_ff      <= 1'b1;
         for (int i = 0; i < NPG; i++) begin
            len_ff[i] <= '0;
         end
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         rsp_last_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               sdps_pkg::CSR_PAGE_COUNT:    page_count_ff    <= csr_data[3:0];
               sdps_pkg::CSR_ROTATE_PERIOD: rotate_period_ff <= csr_data;
               sdps_pkg::CSR_SCROLL_ON:     scroll_on_ff     <= csr_data[0];
               sdps_pkg::CSR_SCROLL_PERIOD: scroll_period_ff <= csr_data;
               sdps_pkg::CSR_BLINK_ENABLE:  blink_en_ff      <= csr_data[0];
               sdps_pkg::CSR_BLINK_PERIOD:  blink_period_ff  <= csr_data;
               default: ;
            endcase
         end

         if (ctl.tick) begin
            if (scroll_on_ff && !rotate_now) begin
               if (scroll_count_ff >= scroll_period_ff) begin
                  scroll_count_ff  <= '0;
                  scroll_offset_ff <= scroll_offset_ff + 8'sd1;
               end else begin
                  scroll_count_ff <= scroll_count_ff + 1'b1;
               end
            end
            // rotation overrides the scroll step
            if (page_count_ff > 4'd1) begin
               if (rotate_count_ff >= rotate_period_ff) begin
                  rotate_count_ff  <= '0;
                  scroll_count_ff  <= '0;
                  scroll_offset_ff <= -8'sd1;
                  if (({1'b0, cur_page_ff} + 4'd1 >= page_count_ff)
                      || (cur_page_ff == 3'd7)) begin
                     cur_page_ff <= '0;
                  end else begin
                     cur_page_ff <= cur_page_ff + 1'b1;
                  end
               end else begin
                  rotate_count_ff <= rotate_count_ff + 1'b1;
               end
            end else begin
               cur_page_ff <= '0;
            end
            if (blink_en_ff) begin
               if (blink_count_ff >= blink_period_ff) begin
                  blink_count_ff <= '0;
                  blink_phase_ff <= !blink_phase_ff;
               end else begin
                  blink_count_ff <= blink_count_ff + 1'b1;
               end
            end
         end

         if (ctl.clear) begin
            for (int i = 0; i < NPG; i++) begin
               len_ff[i] <= '0;
            end
         end

         if (ctl.put_direct || ctl.merge_fin) begin
            if (item_ff.end_of_text) begin
               if (put_pg_ok) begin
                  len_ff[put_len_idx] <= commit_len;
               end
               wi_ff       <= '0;
               prev_dot_ff <= 1'b0;
               at_start_ff <= 1'b1;
            end else begin
               wi_ff       <= wi_in;
               prev_dot_ff <= is_dot;
               at_start_ff <= 1'b0;
            end
         end

         if (ctl.draw_setup) begin
            cnt_ff <= '0;
            if (scroll_reset) begin
               scroll_offset_ff <= '0;
            end
         end
         if (ctl.draw_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         rsp_valid_ff <= ctl.draw_step;
         rsp_last_ff  <= ctl.draw_step && draw_last;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_item.digit_index  = rsp_digit_ff;
   assign rsp_item.segment_char = rsp_blank_ff ? sdps_pkg::BLANK_CHAR : rd_data_ff;
   assign rsp_item.last_digit   = rsp_last_ff;

   a_rsp_from_draw : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(ctl.draw_step))
      else $error("result strobe without a draw step");

   a_last_digit : assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> (rsp_valid_ff && (rsp_digit_ff == 3'(NUM_EMIT - 1))))
      else $error("last digit flag on the wrong digit");

   a_wi_bound : assert property (@(posedge clock) disable iff (reset)
      int'(wi_ff) <= TEXT_LEN)
      else $error("write index past text length");

   a_merge_order : assert property (@(posedge clock) disable iff (reset)
      ctl.merge_fin |-> $past(ctl.merge_rd))
      else $error("dot merge write without its read");

endmodule

/* sv/segment_display_page_sequencer.sv */
// channel   ports                          handshake
// request   start, busy, req_item          transfer when start high and busy low
// result    rsp_valid, rsp_item            valid high for a single cycle per result, no back pressure
// config    csr_we, csr_index, csr_data    write on any edge with csr_we high
//
// tick, clear and a put each run their own state (ST_TICK, ST_CLEAR, ST_PUT), a put
// of a dot merged into the previous character ST_PUT then ST_MERGE (read, then write back)
// a draw runs a setup state, then one digit read per cycle from the single store
// port, min(DIGITS, 8) reads in all, each result in the cycle after its read
// synchronous reset clears config, timers, page lengths and the put stream, not the store
// the result side cannot stall, so no result is ever held back
module segment_display_page_sequencer #(
   parameter int PAGES    = sdps_pkg::PAGES_DEF,
   parameter int DIGITS   = sdps_pkg::DIGITS_DEF,
   parameter int TEXT_LEN = sdps_pkg::TEXT_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  sdps_pkg::req_type                req_item,
   // result channel
   output logic                             rsp_valid,
   output sdps_pkg::rsp_type                rsp_item,
   // configuration writes
   input  logic                             csr_we,
   input  logic [sdps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sdps_pkg::CSR_DATA_W-1:0]  csr_data
);

   // command and status between sequencer and datapath
   sdps_pkg::ctl_type ctl;
   sdps_pkg::sts_type sts;

   // sequencer: one command at a time, branches on the command code
   sdps_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_item.command),
      .sts     (sts),
      .ctl     (ctl),
      .busy    (busy)
   );

   // datapath: config, timers, put stream, page store and draw window
   sdps_datapath #(
      .PAGES    (PAGES),
      .DIGITS   (DIGITS),
      .TEXT_LEN (TEXT_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
